// File: rtl/core/tbwl_pkg.sv
// ----------------------------------------------------------------------------
// tbwl_pkg
// Shared constants and types of the token bucket window limiter.
// ----------------------------------------------------------------------------
package tbwl_pkg;

  localparam int NUM_CLIENTS = 64;
  localparam int CLIENT_W    = $clog2(NUM_CLIENTS);
  localparam int TIME_BITS   = 32;
  localparam int TOK_W       = 24;
  localparam int RATE_W      = 16;
  localparam int WIN_W       = 8;
  localparam int COUNT_W     = 16;
  localparam int NEED_W      = 16;
  localparam int PROD_W      = TIME_BITS + RATE_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int PADDR_W     = 4;

  localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(100);
  localparam logic [RATE_W-1:0] BURST_RST = RATE_W'(100);
  localparam logic [WIN_W-1:0]  WIN_RST   = WIN_W'(1);

  typedef enum logic [1:0] {
    REG_RATE   = 2'd0,
    REG_BURST  = 2'd1,
    REG_WINDOW = 2'd2,
    REG_MODE   = 2'd3
  } tbwl_reg_t;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } tbwl_state_t;

  typedef struct packed {
    logic [TOK_W-1:0]     tokens;
    logic [TIME_BITS-1:0] refill_at;
    logic [TIME_BITS-1:0] win_start;
    logic [COUNT_W-1:0]   window_count;
  } tbwl_entry_t;

  localparam int ENTRY_W = $bits(tbwl_entry_t);

endpackage

// File: rtl/core/tbwl_ram.sv
// ----------------------------------------------------------------------------
// tbwl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tbwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/token_bucket_window_limiter.sv
// ----------------------------------------------------------------------------
// token_bucket_window_limiter
// Token bucket rate limiter: fixed counting window per client, or shared.
//
// The input channel carries tick transactions, which advance the seconds
// counter, and request transactions with a client index and a token count.
// Every request yields one result transaction on the output channel with
// the admit decision and the tokens left in the bucket; a tick yields none.
// The client table read is issued at the acceptance edge of a request; the
// read state forms the refill product and the calc state does the update,
// the write-back and the result load. A request is accepted only in the
// idle state, set by the one-entry-at-a-time read-modify-write of the
// table, so no new request is taken before the last one is through. The
// result sits in an output register; while the receiver stalls, ticks are
// still taken in the idle state and a following request completes up to
// its last step. Reset clears all client valid marks and the time
// counter, loads the shared bucket with the burst reset value and loads
// the register reset values. The configuration port is APB-style and is
// to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module token_bucket_window_limiter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [tbwl_pkg::CLIENT_W-1:0]   in_client,
  input  logic [tbwl_pkg::NEED_W-1:0]     in_tokens_needed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_allowed,
  output logic [tbwl_pkg::TOK_W-1:0]      out_tokens_left,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbwl_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [tbwl_pkg::RATE_W-1:0] rate_r;
  logic [tbwl_pkg::RATE_W-1:0] burst_r;
  logic [tbwl_pkg::WIN_W-1:0]  window_r;
  logic                        mode_r;
  tbwl_pkg::tbwl_reg_t         reg_sel;

  logic [tbwl_pkg::TIME_BITS-1:0] now_r;
  logic [tbwl_pkg::NUM_CLIENTS-1:0] valid_r;
  logic [tbwl_pkg::TOK_W-1:0]     gtok_r;
  logic [tbwl_pkg::TIME_BITS-1:0] glast_r;

  tbwl_pkg::tbwl_state_t state_r, state_nxt;
  logic accept;
  logic ram_re;
  logic ram_we;
  logic finish;

  logic [tbwl_pkg::CLIENT_W-1:0] client_r;
  logic [tbwl_pkg::NEED_W-1:0]   need_r;

  tbwl_pkg::tbwl_entry_t ram_rdata;
  tbwl_pkg::tbwl_entry_t ram_wdata;
  tbwl_pkg::tbwl_entry_t sel_entry;

  tbwl_pkg::tbwl_entry_t          ent_r;
  logic [tbwl_pkg::PROD_W-1:0]    prod_r;
  logic [tbwl_pkg::TOK_W-1:0]     cap_r;
  logic                           due_r;

  logic [tbwl_pkg::TIME_BITS-1:0] elapsed;
  logic [tbwl_pkg::SUM_W-1:0]     sum;
  logic [tbwl_pkg::TOK_W-1:0]     tok_ref;
  logic [tbwl_pkg::TIME_BITS-1:0] last_ref;
  logic                           consume_ok;
  logic [tbwl_pkg::TOK_W-1:0]     tok_fin;
  logic [tbwl_pkg::TIME_BITS-1:0] welapsed;
  logic                           win_expired;
  logic [tbwl_pkg::TIME_BITS-1:0] wstart_fin;
  logic [tbwl_pkg::COUNT_W-1:0]   wcount_base;
  logic [tbwl_pkg::COUNT_W-1:0]   wcount_fin;
  logic                           allowed_fin;

  logic                       out_valid_r;
  logic                       out_allowed_r;
  logic [tbwl_pkg::TOK_W-1:0] out_tokens_r;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = tbwl_pkg::tbwl_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= tbwl_pkg::RATE_RST;
      burst_r  <= tbwl_pkg::BURST_RST;
      window_r <= tbwl_pkg::WIN_RST;
      mode_r   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        tbwl_pkg::REG_RATE:   rate_r   <= pwdata[tbwl_pkg::RATE_W-1:0];
        tbwl_pkg::REG_BURST:  burst_r  <= pwdata[tbwl_pkg::RATE_W-1:0];
        tbwl_pkg::REG_WINDOW: window_r <= pwdata[tbwl_pkg::WIN_W-1:0];
        tbwl_pkg::REG_MODE:   mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tbwl_pkg::REG_RATE:   prdata = {16'd0, rate_r};
      tbwl_pkg::REG_BURST:  prdata = {16'd0, burst_r};
      tbwl_pkg::REG_WINDOW: prdata = {24'd0, window_r};
      tbwl_pkg::REG_MODE:   prdata = {31'd0, mode_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Sequencer.
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbwl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbwl_pkg::ST_IDLE: begin
        if (accept && in_func == tbwl_pkg::FUNC_REQUEST) begin
          state_nxt = tbwl_pkg::ST_READ;
        end
      end
      tbwl_pkg::ST_READ: state_nxt = tbwl_pkg::ST_CALC;
      tbwl_pkg::ST_CALC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = tbwl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbwl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    finish   = 1'b0;
    case (state_r)
      tbwl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_valid;
      end
      tbwl_pkg::ST_READ: ;
      tbwl_pkg::ST_CALC: finish = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign ram_we = finish && mode_r;

  // Client table.
  tbwl_ram #(
    .WIDTH (tbwl_pkg::ENTRY_W),
    .DEPTH (tbwl_pkg::NUM_CLIENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (client_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_client),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && in_func == tbwl_pkg::FUNC_REQUEST) begin
      client_r <= in_client;
      need_r   <= in_tokens_needed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (accept && in_func == tbwl_pkg::FUNC_TICK) begin
      now_r <= now_r + tbwl_pkg::TIME_BITS'(1);
    end
  end

  // Entry selection and refill products.
  always_comb begin
    if (!mode_r) begin
      sel_entry.tokens       = gtok_r;
      sel_entry.refill_at    = glast_r;
      sel_entry.win_start    = now_r;
      sel_entry.window_count = '0;
    end else if (!valid_r[client_r]) begin
      sel_entry.tokens       = tbwl_pkg::TOK_W'(burst_r);
      sel_entry.refill_at    = now_r;
      sel_entry.win_start    = now_r;
      sel_entry.window_count = '0;
    end else begin
      sel_entry = ram_rdata;
    end
  end

  assign elapsed = now_r - sel_entry.refill_at;

  always_ff @(posedge clk) begin
    if (state_r == tbwl_pkg::ST_READ) begin
      ent_r  <= sel_entry;
      due_r  <= elapsed >= tbwl_pkg::TIME_BITS'(window_r);
      prod_r <= tbwl_pkg::PROD_W'(elapsed) * tbwl_pkg::PROD_W'(rate_r);
      cap_r  <= tbwl_pkg::TOK_W'(rate_r) * tbwl_pkg::TOK_W'(window_r);
    end
  end

  // Refill, consume and window update.
  always_comb begin
    sum      = tbwl_pkg::SUM_W'(ent_r.tokens) + tbwl_pkg::SUM_W'(prod_r);
    tok_ref  = ent_r.tokens;
    last_ref = ent_r.refill_at;
    if (due_r) begin
      last_ref = now_r;
      if (sum > tbwl_pkg::SUM_W'(cap_r)) begin
        tok_ref = cap_r;
      end else begin
        tok_ref = sum[tbwl_pkg::TOK_W-1:0];
      end
    end
    consume_ok = tok_ref >= tbwl_pkg::TOK_W'(need_r);
    tok_fin    = consume_ok ? tok_ref - tbwl_pkg::TOK_W'(need_r) : tok_ref;

    welapsed    = now_r - ent_r.win_start;
    win_expired = welapsed >= tbwl_pkg::TIME_BITS'(window_r);
    wstart_fin  = ent_r.win_start;
    wcount_base = ent_r.window_count;
    if (consume_ok && win_expired) begin
      wstart_fin  = now_r;
      wcount_base = '0;
    end
    wcount_fin  = wcount_base;
    allowed_fin = consume_ok;
    if (mode_r && consume_ok) begin
      if (wcount_base >= rate_r) begin
        allowed_fin = 1'b0;
      end else begin
        wcount_fin = wcount_base + tbwl_pkg::COUNT_W'(1);
      end
    end
  end

  assign ram_wdata.tokens       = tok_fin;
  assign ram_wdata.refill_at    = last_ref;
  assign ram_wdata.win_start    = wstart_fin;
  assign ram_wdata.window_count = wcount_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      gtok_r  <= tbwl_pkg::TOK_W'(tbwl_pkg::BURST_RST);
      glast_r <= '0;
    end else if (finish) begin
      if (mode_r) begin
        valid_r[client_r] <= 1'b1;
      end else begin
        gtok_r  <= tok_fin;
        glast_r <= last_ref;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_allowed_r <= allowed_fin;
      out_tokens_r  <= tok_fin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_allowed     = out_allowed_r;
  assign out_tokens_left = out_tokens_r;

endmodule
